/* rtl/srs_pkg.sv */
`timescale 1ns / 1ps

package srs_pkg;

  localparam int SampleBits = 16;
  localparam int MaxSamples = 65536;

  localparam int CntW = $clog2(MaxSamples + 1);
  localparam int AbsW = SampleBits + CntW - 1;
  localparam int SqW  = 2 * SampleBits + CntW - 2;

  localparam int MeanW  = 16;
  localparam int RmsW   = 16;
  localparam int P2pW   = 16;
  localparam int CountW = 17;

  localparam int RemW  = (CntW + 1 > SampleBits + 3) ? CntW + 1 : SampleBits + 3;
  localparam int StepW = $clog2(SqW);

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [CntW-1:0]              count_t;

endpackage

/* rtl/srs_if.sv */
`timescale 1ns / 1ps

interface srs_in_if;
  logic                valid;
  logic                ready;
  srs_pkg::sample_t    sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface srs_out_if;
  logic                        valid;
  logic                        ready;
  logic [srs_pkg::MeanW-1:0]   mean_abs;
  logic [srs_pkg::RmsW-1:0]    rms;
  logic [srs_pkg::P2pW-1:0]    peak_to_peak;
  logic [srs_pkg::CountW-1:0]  sample_count;
  logic                        overflow;

  modport source (output valid, output mean_abs, output rms, output peak_to_peak,
                  output sample_count, output overflow, input ready);
  modport sink (input valid, input mean_abs, input rms, input peak_to_peak,
                input sample_count, input overflow, output ready);
endinterface

/* rtl/surface_roughness_stats.sv */
`timescale 1ns / 1ps

// Surface roughness statistics. While a run is being collected the block takes one height
// item per cycle and updates the running maximum, minimum, sum of absolute values, sum of
// squares and count. The item marked last closes the run: one shared remainder
// subtractor then computes Ra by a radix-2 divide of the absolute sum, the mean square
// by a radix-2 divide of the square sum and Rq by a digit-by-digit square root; no new
// item is accepted until all three are done and the output is free of the previous
// result. Items beyond 65536 in one run are dropped and flagged in the result.
module surface_roughness_stats (
  input  logic      clk_i,
  input  logic      rst_ni,
  srs_in_if.sink    in_i,
  srs_out_if.source res_o
);
  import srs_pkg::*;

  typedef enum logic [2:0] {
    S_ACC,
    S_DIVA,
    S_DIVB,
    S_SQRT,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  sample_t                 max_q, max_d, min_q, min_d;
  logic [AbsW-1:0]         sum_abs_q, sum_abs_d;
  logic [SqW-1:0]          sum_sq_q, sum_sq_d;
  count_t                  cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic [RemW-1:0]         rem_q, rem_d;
  logic [SqW-1:0]          dvd_q, dvd_d;
  logic [SqW-1:0]          quo_q, quo_d;
  logic [StepW-1:0]        step_q, step_d;
  logic [MeanW-1:0]        ra_q, ra_d;
  logic [RmsW-1:0]         rq_q, rq_d;

  logic                    out_valid_q, out_valid_d;
  logic [MeanW-1:0]        mean_q, mean_d;
  logic [RmsW-1:0]         rms_q, rms_d;
  logic [P2pW-1:0]         p2p_q, p2p_d;
  logic [CountW-1:0]       count_q, count_d;
  logic                    flag_q, flag_d;

  logic                    accept;
  logic [SampleBits-1:0]   s_u;
  logic [SampleBits-1:0]   mag;
  logic [2*SampleBits-1:0] mag_sq;
  logic [RemW-1:0]         op_a, op_b;
  logic [RemW:0]           diff;
  logic                    ge;
  logic [RemW-1:0]         rem_next;
  logic [SqW-1:0]          quo_next;
  logic                    out_free;

  assign in_i.ready = (state_q == S_ACC);
  assign accept     = in_i.valid && in_i.ready;
  assign s_u        = in_i.sample;
  assign mag        = s_u[SampleBits-1] ? (~s_u + 1'b1) : s_u;
  assign mag_sq     = mag * mag;
  assign out_free   = !out_valid_q || res_o.ready;

  // Shared compare-subtract: divide step or square-root step on the partial remainder.
  always_comb begin
    if (state_q == S_SQRT) begin
      op_a = {rem_q[RemW-3:0], dvd_q[SqW-1:SqW-2]};
      op_b = {quo_q[RemW-3:0], 2'b01};
    end else begin
      op_a = {rem_q[RemW-2:0], dvd_q[SqW-1]};
      op_b = RemW'(cnt_q);
    end
  end

  assign diff     = {1'b0, op_a} - {1'b0, op_b};
  assign ge       = !diff[RemW];
  assign rem_next = ge ? diff[RemW-1:0] : op_a;
  assign quo_next = {quo_q[SqW-2:0], ge};

  always_comb begin
    state_d     = state_q;
    max_d       = max_q;
    min_d       = min_q;
    sum_abs_d   = sum_abs_q;
    sum_sq_d    = sum_sq_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    step_d      = step_q;
    ra_d        = ra_q;
    rq_d        = rq_q;
    out_valid_d = out_valid_q && !res_o.ready;
    mean_d      = mean_q;
    rms_d       = rms_q;
    p2p_d       = p2p_q;
    count_d     = count_q;
    flag_d      = flag_q;

    case (state_q)
      S_ACC: begin
        if (accept) begin
          if (cnt_q < CntW'(MaxSamples)) begin
            if (cnt_q == '0) begin
              max_d = in_i.sample;
              min_d = in_i.sample;
            end else if (in_i.sample > max_q) begin
              max_d = in_i.sample;
            end else if (in_i.sample < min_q) begin
              min_d = in_i.sample;
            end
            sum_abs_d = sum_abs_q + AbsW'(mag);
            sum_sq_d  = sum_sq_q + SqW'(mag_sq);
            cnt_d     = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = S_DIVA;
            dvd_d   = {sum_abs_d, (SqW - AbsW)'(0)};
            rem_d   = '0;
            quo_d   = '0;
            step_d  = '0;
          end
        end
      end
      S_DIVA: begin
        rem_d  = rem_next;
        quo_d  = quo_next;
        dvd_d  = {dvd_q[SqW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(AbsW - 1)) begin
          ra_d    = quo_next[MeanW-1:0];
          state_d = S_DIVB;
          dvd_d   = sum_sq_q;
          rem_d   = '0;
          quo_d   = '0;
          step_d  = '0;
        end
      end
      S_DIVB: begin
        rem_d  = rem_next;
        quo_d  = quo_next;
        dvd_d  = {dvd_q[SqW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SqW - 1)) begin
          state_d = S_SQRT;
          dvd_d   = {quo_next[2*SampleBits-1:0], (SqW - 2 * SampleBits)'(0)};
          rem_d   = '0;
          quo_d   = '0;
          step_d  = '0;
        end
      end
      S_SQRT: begin
        rem_d  = rem_next;
        quo_d  = quo_next;
        dvd_d  = {dvd_q[SqW-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SampleBits - 1)) begin
          rq_d    = quo_next[RmsW-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          mean_d      = ra_q;
          rms_d       = rq_q;
          p2p_d       = P2pW'(max_q - min_q);
          count_d     = CountW'(cnt_q);
          flag_d      = ovf_q;
          max_d       = '0;
          min_d       = '0;
          sum_abs_d   = '0;
          sum_sq_d    = '0;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      max_q       <= '0;
      min_q       <= '0;
      sum_abs_q   <= '0;
      sum_sq_q    <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_q       <= max_d;
      min_q       <= min_d;
      sum_abs_q   <= sum_abs_d;
      sum_sq_q    <= sum_sq_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    quo_q   <= quo_d;
    ra_q    <= ra_d;
    rq_q    <= rq_d;
    mean_q  <= mean_d;
    rms_q   <= rms_d;
    p2p_q   <= p2p_d;
    count_q <= count_d;
    flag_q  <= flag_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.mean_abs     = mean_q;
  assign res_o.rms          = rms_q;
  assign res_o.peak_to_peak = p2p_q;
  assign res_o.sample_count = count_q;
  assign res_o.overflow     = flag_q;

  a_cnt_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSamples))
    else $error("Sample count exceeds the run limit.");

  a_last_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last) |=> !in_i.ready)
    else $error("Input still ready after the last item of a run.");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("Result raised outside the completion state.");

  a_run_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q == S_DONE) && state_q == S_ACC) |-> (cnt_q == '0 && !ovf_q))
    else $error("Run state not cleared after a result.");

  a_max_ge_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (max_q >= min_q))
    else $error("Running maximum below running minimum.");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import srs_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int RandItems  = 1850;

  typedef struct packed {
    logic [MeanW-1:0]  mean_abs;
    logic [RmsW-1:0]   rms;
    logic [P2pW-1:0]   peak_to_peak;
    logic [CountW-1:0] sample_count;
    logic              overflow;
  } rough_res_t;

  typedef struct {
    sample_t    smp;
    logic       lst;
    bit         typed;
    rough_res_t res;
  } plan_row_t;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   errors;
  int   quiet;

  rough_res_t roughness_q[$];

  sample_t         hi_mark;
  sample_t         lo_mark;
  longint unsigned abs_acc;
  longint unsigned sq_acc;
  int unsigned     n_acc;
  bit              ovf_seen;

  srs_in_if  in_bus ();
  srs_out_if res_bus ();

  surface_roughness_stats i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .res_o  (res_bus)
  );

  plan_row_t plan [24] = '{
    '{16'sd0,      1'b1, 1'b1, '{16'd0,     16'd0,     16'd0,     17'd1, 1'b0}},
    '{-16'sd32768, 1'b1, 1'b1, '{16'd32768, 16'd32768, 16'd0,     17'd1, 1'b0}},
    '{16'sd32767,  1'b1, 1'b1, '{16'd32767, 16'd32767, 16'd0,     17'd1, 1'b0}},
    '{-16'sd1,     1'b1, 1'b1, '{16'd1,     16'd1,     16'd0,     17'd1, 1'b0}},
    '{-16'sd32768, 1'b0, 1'b0, '0},
    '{16'sd32767,  1'b1, 1'b1, '{16'd32767, 16'd32767, 16'd65535, 17'd2, 1'b0}},
    '{16'sd32767,  1'b0, 1'b0, '0},
    '{-16'sd32768, 1'b1, 1'b1, '{16'd32767, 16'd32767, 16'd65535, 17'd2, 1'b0}},
    '{16'sd1,      1'b0, 1'b0, '0},
    '{16'sd2,      1'b0, 1'b0, '0},
    '{16'sd3,      1'b0, 1'b0, '0},
    '{-16'sd5,     1'b0, 1'b0, '0},
    '{16'sd4,      1'b1, 1'b0, '0},
    '{16'sd100,    1'b0, 1'b0, '0},
    '{16'sd100,    1'b0, 1'b0, '0},
    '{16'sd100,    1'b1, 1'b1, '{16'd100,   16'd100,   16'd0,     17'd3, 1'b0}},
    '{16'sd5,      1'b0, 1'b0, '0},
    '{16'sd4,      1'b0, 1'b0, '0},
    '{16'sd3,      1'b0, 1'b0, '0},
    '{-16'sd7,     1'b1, 1'b0, '0},
    '{-16'sd32768, 1'b0, 1'b0, '0},
    '{-16'sd32768, 1'b1, 1'b1, '{16'd32768, 16'd32768, 16'd0,     17'd2, 1'b0}},
    '{16'sd21845,  1'b0, 1'b0, '0},
    '{-16'sd21846, 1'b1, 1'b0, '0}
  };

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 24;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void clear_roughness();
    hi_mark  = '0;
    lo_mark  = '0;
    abs_acc  = 0;
    sq_acc   = 0;
    n_acc    = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic bit roughness_step(input sample_t s, input logic lst,
                                        output rough_res_t r);
    int              sv;
    int              span;
    longint unsigned mag;
    longint unsigned ra;
    longint unsigned rq;
    sv = s;
    mag = longint'(sv < 0 ? -sv : sv);
    r = '0;
    if (n_acc < MaxSamples) begin
      if (n_acc == 0) begin
        hi_mark = s;
        lo_mark = s;
      end else if (s > hi_mark) begin
        hi_mark = s;
      end else if (s < lo_mark) begin
        lo_mark = s;
      end
      abs_acc += mag;
      sq_acc  += mag * mag;
      n_acc++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!lst) return 1'b0;
    ra = 0;
    rq = 0;
    if (n_acc != 0) begin
      ra = abs_acc / n_acc;
      rq = floor_root(sq_acc / n_acc);
    end
    span = int'(hi_mark) - int'(lo_mark);
    r.mean_abs     = ra[MeanW-1:0];
    r.rms          = rq[RmsW-1:0];
    r.peak_to_peak = span[P2pW-1:0];
    r.sample_count = n_acc[CountW-1:0];
    r.overflow     = ovf_seen;
    clear_roughness();
    return 1'b1;
  endfunction

  function automatic sample_t pick_sample();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return sample_t'($signed($urandom_range(16)) - 8);
      default: return raw[15:0];
    endcase
  endfunction

  task automatic push_item(input sample_t s, input logic lst, input bit typed,
                           input rough_res_t want);
    rough_res_t got;
    while (!no_idle && $urandom_range(99) < 15) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    in_bus.last   <= lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (roughness_step(s, lst, got)) roughness_q.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_bus.ready <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    rough_res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        if (roughness_q.size() == 0) begin
          $display("%0t: result with no expected item, actual mean_abs %0d rms %0d",
                   $time, res_bus.mean_abs, res_bus.rms);
          errors++;
        end else begin
          want = roughness_q.pop_front();
          report_field("mean_abs", want.mean_abs, res_bus.mean_abs);
          report_field("rms", want.rms, res_bus.rms);
          report_field("peak_to_peak", want.peak_to_peak, res_bus.peak_to_peak);
          report_field("sample_count", want.sample_count, res_bus.sample_count);
          report_field("overflow", want.overflow, res_bus.overflow);
        end
      end
    end
  end

  initial begin
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired", $time);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int sent;
    int len;
    errors        = 0;
    no_idle       = 1'b0;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.sample = '0;
    in_bus.last   = 1'b0;
    clear_roughness();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) push_item(plan[i].smp, plan[i].lst, plan[i].typed, plan[i].res);

    sent = 0;
    while (sent < RandItems) begin
      no_idle = (sent >= 700 && sent < 1000);
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 1) : $urandom_range(12, 1);
      for (int k = 0; k < len; k++) push_item(pick_sample(), k == len - 1, 1'b0, '0);
      sent += len;
    end
    no_idle = 1'b0;
    in_bus.valid <= 1'b0;

    while (roughness_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && roughness_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
